### hw/rtl/lkvc_pkg.sv
// lkvc_pkg: shared types and constants for the LRU key-value cache.
// No dependencies; imported by the interfaces and all RTL modules.
package lkvc_pkg;

  localparam int unsigned MaxEntriesDefault = 16;
  localparam int unsigned KeyWidth = 32;
  localparam int unsigned ValWidth = 32;
  localparam int unsigned CfgWidth = 5;

  localparam logic [CfgWidth-1:0] CfgReset = 5'd16;
  localparam logic signed [ValWidth-1:0] MissValue = -32'sd1;
  localparam logic signed [ValWidth-1:0] PutValue = 32'sd0;

  localparam logic ModeGet = 1'b0;
  localparam logic ModePut = 1'b1;

  // one-cycle strobes from controller to datapath
  typedef struct packed {
    logic load_in;   // capture request transaction
    logic compare;   // key match, slot choice, value read
    logic update;    // write state, load response register
  } dp_cmd_t;

endpackage

### hw/rtl/lkvc_req_if.sv
// lkvc_req_if: request channel (get/put transaction) with valid/ready.
// Depends on lkvc_pkg for field widths.
interface lkvc_req_if;
  import lkvc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [KeyWidth-1:0] lookup_key;
  logic signed [ValWidth-1:0] write_value;

  modport source (output valid, mode, lookup_key, write_value, input ready);
  modport sink (input valid, mode, lookup_key, write_value, output ready);
endinterface

### hw/rtl/lkvc_rsp_if.sv
// lkvc_rsp_if: response channel (hit flag and read value) with valid/ready.
// Depends on lkvc_pkg for field widths.
interface lkvc_rsp_if;
  import lkvc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic signed [ValWidth-1:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink (input valid, hit, read_value, output ready);
endinterface

### hw/rtl/lkvc_ctrl.sv
// lkvc_ctrl: sequencing FSM (accept, compare, update) and response valid.
// Depends on lkvc_pkg for the command struct.
module lkvc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output lkvc_pkg::dp_cmd_t cmd_o
);
  import lkvc_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCmp  = 2'd1;
  localparam logic [1:0] StUpd  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       slot_free;

  assign slot_free   = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == StIdle);
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d       = state_q;
    rsp_valid_d   = rsp_valid_q && !rsp_ready_i;
    cmd_o         = '0;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StCmp;
        end
      end
      StCmp: begin
        cmd_o.compare = 1'b1;
        state_d       = StUpd;
      end
      StUpd: begin
        // hold until the response register can take the new transaction
        if (slot_free) begin
          cmd_o.update = 1'b1;
          rsp_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

### hw/rtl/lkvc_datapath.sv
// lkvc_datapath: key CAM lanes, recency ranks, value memory, capacity
// register and response payload. Depends on lkvc_pkg.
module lkvc_datapath #(
  parameter int unsigned MaxEntries = lkvc_pkg::MaxEntriesDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lkvc_pkg::dp_cmd_t                    cmd_i,
  input  logic                                 cfg_we_i,
  input  logic [lkvc_pkg::CfgWidth-1:0]        cfg_wdata_i,
  input  logic                                 mode_i,
  input  logic signed [lkvc_pkg::KeyWidth-1:0] lookup_key_i,
  input  logic signed [lkvc_pkg::ValWidth-1:0] write_value_i,
  output logic                                 hit_o,
  output logic signed [lkvc_pkg::ValWidth-1:0] read_value_o
);
  import lkvc_pkg::*;

  localparam int unsigned RankW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW  = $clog2(MaxEntries + 1);
  localparam int unsigned CapW  = (CntW > CfgWidth) ? CntW : CfgWidth;
  localparam logic [CapW-1:0] CapMax = CapW'(MaxEntries);

  // capacity register
  logic [CfgWidth-1:0] cfg_q;

  // per-entry state
  logic signed [KeyWidth-1:0] key_q [MaxEntries];
  logic [RankW-1:0]           rank_q [MaxEntries];
  logic [MaxEntries-1:0]      valid_q;
  logic [CntW-1:0]            count_q;
  logic signed [ValWidth-1:0] value_mem [MaxEntries];

  // captured request
  logic                       put_q;
  logic signed [KeyWidth-1:0] in_key_q;
  logic signed [ValWidth-1:0] in_val_q;

  // compare results
  logic                       hit_q;
  logic                       insert_q;
  logic [MaxEntries-1:0]      tgt_q;
  logic [RankW-1:0]           tgt_idx_q;
  logic [RankW-1:0]           tgt_rank_q;
  logic signed [ValWidth-1:0] rd_q;

  // response payload
  logic                       hit_out_q;
  logic signed [ValWidth-1:0] rd_out_q, rd_out_d;

  logic [MaxEntries-1:0] match_vec, free_vec, free_first, victim_vec, tgt_vec;
  logic [CapW-1:0]       cap_c, cfg_ext, cnt_ext;
  logic [RankW-1:0]      lru_rank, tgt_idx, tgt_rank;
  logic                  hit_c, has_free;

  assign cfg_ext  = CapW'(cfg_q);
  assign cnt_ext  = CapW'(count_q);
  assign lru_rank = RankW'(count_q - 1'b1);

  always_comb begin
    if (cfg_ext == '0) begin
      cap_c = CapW'(1);
    end else if (cfg_ext > CapMax) begin
      cap_c = CapMax;
    end else begin
      cap_c = cfg_ext;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxEntries; i++) begin
      match_vec[i]  = valid_q[i] && (key_q[i] == in_key_q);
      // with a full store the valid ranks are 0..count-1, so LRU is count-1
      victim_vec[i] = valid_q[i] && (rank_q[i] == lru_rank);
    end
    free_vec   = ~valid_q;
    free_first = free_vec & (~free_vec + 1'b1);
    hit_c      = |match_vec;
    has_free   = (|free_vec) && (cnt_ext < cap_c);

    if (hit_c) begin
      tgt_vec = match_vec;
    end else if (put_q) begin
      tgt_vec = has_free ? free_first : victim_vec;
    end else begin
      tgt_vec = '0;
    end

    tgt_idx  = '0;
    tgt_rank = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      if (tgt_vec[i]) begin
        tgt_idx  = tgt_idx | RankW'(i);
        tgt_rank = tgt_rank | rank_q[i];
      end
    end
  end

  always_comb begin
    if (put_q == ModePut) begin
      rd_out_d = PutValue;
    end else if (hit_q) begin
      rd_out_d = rd_q;
    end else begin
      rd_out_d = MissValue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // request capture, compare results and response payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      put_q    <= mode_i;
      in_key_q <= lookup_key_i;
      in_val_q <= write_value_i;
    end
    if (cmd_i.compare) begin
      hit_q      <= hit_c;
      insert_q   <= put_q && !hit_c && has_free;
      tgt_q      <= tgt_vec;
      tgt_idx_q  <= tgt_idx;
      tgt_rank_q <= tgt_rank;
    end
    if (cmd_i.update) begin
      hit_out_q <= hit_q;
      rd_out_q  <= rd_out_d;
    end
  end

  // value memory: one read port, one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      rd_q <= value_mem[tgt_idx];
    end
    if (cmd_i.update && put_q) begin
      value_mem[tgt_idx_q] <= in_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxEntries; i++) begin
      if (cmd_i.update && put_q && tgt_q[i]) begin
        key_q[i] <= in_key_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < MaxEntries; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      for (int i = 0; i < MaxEntries; i++) begin
        if (tgt_q[i]) begin
          valid_q[i] <= 1'b1;
          rank_q[i]  <= '0;
        end else if (valid_q[i] && (insert_q || (|tgt_q && rank_q[i] < tgt_rank_q))) begin
          rank_q[i] <= rank_q[i] + 1'b1;
        end
      end
      if (insert_q) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  assign hit_o        = hit_out_q;
  assign read_value_o = rd_out_q;

endmodule

### hw/rtl/lru_key_value_cache_top.sv
// LRU key-value cache, fully associative, MaxEntries entries.
// After the request transaction the controller runs compare, then update, which
// registers response valid; update waits while the response register is full.
// A new request is taken only once the controller is idle again: it runs capture,
// compare and update in turn, so transactions do not overlap.
// Reset (async, active low) empties the store and sets capacity to 16.
module lru_key_value_cache_top #(
  parameter int unsigned MaxEntries = lkvc_pkg::MaxEntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lkvc_req_if.sink                      req,
  lkvc_rsp_if.source                    rsp,
  input  logic                          cfg_we_i,
  input  logic [lkvc_pkg::CfgWidth-1:0] cfg_wdata_i
);
  import lkvc_pkg::*;

  dp_cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .cmd_o       (cmd)
  );

  lkvc_datapath #(
    .MaxEntries (MaxEntries)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mode_i        (req.mode),
    .lookup_key_i  (req.lookup_key),
    .write_value_i (req.write_value),
    .hit_o         (rsp.hit),
    .read_value_o  (rsp.read_value)
  );

endmodule

### test/lru_key_value_cache_top_test.sv
// Self-checking testbench for lru_key_value_cache_top: directed table then random get/put traffic,
// each response checked against a typed result or a behavioral LRU cache in step with the DUT.
// Depends on lkvc_pkg, lkvc_req_if, lkvc_rsp_if and the cache RTL; no files or arguments.
module lru_key_value_cache_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lkvc_pkg::*;

  localparam int Slots = MaxEntriesDefault;
  localparam int RandomPhases = 12;
  localparam int ItemsPerPhase = 125;
  localparam int HoldCycles = 300;
  localparam int StallLimit = 5000;
  localparam int DirRows = 25;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        mode;
    logic [31:0] key;
    logic [31:0] value;    // write value, or register value for a config row
    logic        typed;    // expected result given in the row
    logic        exp_hit;
    logic [31:0] exp_val;
  } dir_row_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
  } lookup_reply_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgWidth-1:0] cfg_wdata_i;

  lkvc_req_if req_ch ();
  lkvc_rsp_if rsp_ch ();

  lru_key_value_cache_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // behavioral cache state
  logic [31:0]         slot_key [Slots];
  logic [31:0]         slot_val [Slots];
  bit                  slot_live [Slots];
  int                  slot_age [Slots];   // 0 = most recent
  int                  live_count;
  logic [CfgWidth-1:0] capacity_reg;

  lookup_reply_t replies_due [$];
  int            mismatch_count;
  int            send_idle_pct;
  int            recv_idle_pct;
  bit            hold_req;

  // expectation typed into the directed table for the transaction on the bus
  logic        cur_typed;
  logic        cur_exp_hit;
  logic [31:0] cur_exp_val;

  logic [31:0] key_pool [32];

  dir_row_t directed_rows [DirRows] = '{
    '{RowItem, ModeGet, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MissValue},
    '{RowItem, ModeGet, 32'h8000_0000, 32'hffff_ffff, 1'b1, 1'b0, MissValue},
    '{RowItem, ModePut, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0, PutValue},
    '{RowItem, ModeGet, 32'h7fff_ffff, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{RowItem, ModePut, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0, PutValue},
    '{RowItem, ModePut, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, 1'b1, PutValue},
    // stored -1 comes back with hit set, unlike a miss
    '{RowItem, ModeGet, 32'h7fff_ffff, 32'h1234_5678, 1'b1, 1'b1, 32'hffff_ffff},
    '{RowItem, ModeGet, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b0, MissValue},
    // zero capacity acts as one, below the current contents
    '{RowCfg,  ModeGet, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{RowItem, ModePut, 32'h0000_0000, 32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{RowItem, ModeGet, 32'h8000_0000, 32'hdead_beef, 1'b0, 1'b0, 32'h0},
    '{RowItem, ModeGet, 32'h7fff_ffff, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{RowItem, ModeGet, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    // above the maximum acts as the maximum
    '{RowCfg,  ModeGet, 32'h0000_0000, 32'h0000_001f, 1'b0, 1'b0, 32'h0},
    '{RowItem, ModePut, 32'h0000_0001, 32'h0000_0011, 1'b0, 1'b0, 32'h0},
    '{RowItem, ModePut, 32'h0000_0002, 32'h0000_0022, 1'b0, 1'b0, 32'h0},
    '{RowItem, ModePut, 32'h0000_0003, 32'h0000_0033, 1'b0, 1'b0, 32'h0},
    '{RowItem, ModeGet, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{RowCfg,  ModeGet, 32'h0000_0000, 32'h0000_0003, 1'b0, 1'b0, 32'h0},
    '{RowItem, ModePut, 32'h0000_0004, 32'h0000_0044, 1'b0, 1'b0, 32'h0},
    '{RowItem, ModeGet, 32'h7fff_ffff, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{RowItem, ModeGet, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{RowItem, ModePut, 32'h0000_0001, 32'h1234_5678, 1'b0, 1'b0, 32'h0},
    '{RowCfg,  ModeGet, 32'h0000_0000, 32'h0000_0010, 1'b0, 1'b0, 32'h0},
    '{RowItem, ModeGet, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int capacity_limit();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > Slots) return Slots;
    return int'(capacity_reg);
  endfunction

  // younger live entries age by one, e becomes most recent
  function automatic void make_recent(input int e);
    int r;
    r = slot_age[e];
    for (int i = 0; i < Slots; i++) begin
      if (slot_live[i] && i != e && slot_age[i] < r) slot_age[i]++;
    end
    slot_age[e] = 0;
  endfunction

  function automatic void cache_lookup(input logic put, input logic [31:0] key,
                                       input logic [31:0] val, output logic hit,
                                       output logic [31:0] rd);
    int found;
    int slot;
    int victim;
    int oldest;
    found = -1;
    for (int i = 0; i < Slots; i++) begin
      if (found < 0 && slot_live[i] && slot_key[i] == key) found = i;
    end
    if (found >= 0) begin
      hit = 1'b1;
      if (put) begin
        slot_val[found] = val;
        rd = PutValue;
      end else begin
        rd = slot_val[found];
      end
      make_recent(found);
    end else begin
      hit = 1'b0;
      rd = put ? PutValue : MissValue;
      if (put) begin
        slot = -1;
        if (live_count < capacity_limit()) begin
          for (int i = 0; i < Slots; i++) begin
            if (slot < 0 && !slot_live[i]) slot = i;
          end
        end
        if (slot >= 0) begin
          for (int i = 0; i < Slots; i++) begin
            if (slot_live[i]) slot_age[i]++;
          end
          slot_live[slot] = 1'b1;
          slot_age[slot] = 0;
          slot_key[slot] = key;
          slot_val[slot] = val;
          live_count++;
        end else begin
          victim = -1;
          oldest = 0;
          for (int i = 0; i < Slots; i++) begin
            if (slot_live[i] && (victim < 0 || slot_age[i] > oldest)) begin
              victim = i;
              oldest = slot_age[i];
            end
          end
          slot_key[victim] = key;
          slot_val[victim] = val;
          make_recent(victim);
        end
      end
    end
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_lookup(input logic mode, input logic [31:0] key, input logic [31:0] val,
                             input logic typed, input logic exp_hit,
                             input logic [31:0] exp_val);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= mode;
    req_ch.lookup_key  <= key;
    req_ch.write_value <= val;
    cur_typed   = typed;
    cur_exp_hit = exp_hit;
    cur_exp_val = exp_val;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  // register writes only with the cache drained
  task automatic program_capacity(input logic [CfgWidth-1:0] value);
    req_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= value;
    capacity_reg = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : rsp_side
    int hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : scoreboard
    lookup_reply_t due;
    logic          pred_hit;
    logic [31:0]   pred_val;
    static int     quiet_cycles = 0;
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (replies_due.size() == 0) begin
        $error("response transaction with no request outstanding: hit %0b read_value %h",
               rsp_ch.hit, rsp_ch.read_value);
        mismatch_count++;
      end else begin
        due = replies_due.pop_front();
        if (rsp_ch.hit !== due.hit) begin
          $error("hit: expected %0b, actual %0b", due.hit, rsp_ch.hit);
          mismatch_count++;
        end
        if (rsp_ch.read_value !== due.value) begin
          $error("read_value: expected %h, actual %h", due.value, rsp_ch.read_value);
          mismatch_count++;
        end
      end
    end
    if (req_ch.valid && req_ch.ready) begin
      cache_lookup(req_ch.mode, req_ch.lookup_key, req_ch.write_value, pred_hit, pred_val);
      if (cur_typed) due = '{hit: cur_exp_hit, value: cur_exp_val};
      else due = '{hit: pred_hit, value: pred_val};
      replies_due.push_back(due);
    end
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t      row;
    logic          mode;
    logic [31:0]   key;
    logic [31:0]   val;
    int            pick;
    logic [CfgWidth-1:0] cap_plan [RandomPhases];

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_ch.valid       = 1'b0;
    req_ch.mode        = ModeGet;
    req_ch.lookup_key  = '0;
    req_ch.write_value = '0;
    rsp_ch.ready       = 1'b0;
    cur_typed          = 1'b0;
    cur_exp_hit        = 1'b0;
    cur_exp_val        = '0;
    hold_req           = 1'b0;
    mismatch_count     = 0;
    capacity_reg       = CfgReset;
    live_count         = 0;
    for (int i = 0; i < Slots; i++) begin
      slot_live[i] = 1'b0;
      slot_age[i]  = 0;
      slot_key[i]  = '0;
      slot_val[i]  = '0;
    end
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;
    for (int i = 4; i < 32; i++) key_pool[i] = $urandom;
    cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd8, 5'd5, 5'd2, 5'd16, 5'd12, 5'd9};
    cap_plan[7]  = CfgWidth'($urandom_range(0, 31));
    cap_plan[11] = CfgWidth'($urandom_range(0, 31));
    send_idle_pct = 31;
    recv_idle_pct = 78;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == RowCfg) begin
        program_capacity(row.value[CfgWidth-1:0]);
      end else begin
        send_lookup(row.mode, row.key, row.value, row.typed, row.exp_hit, row.exp_val);
      end
    end

    for (int phase = 0; phase < RandomPhases; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 31;
        recv_idle_pct = 78;
      end else if (phase < 8) begin
        send_idle_pct = 78;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_capacity(cap_plan[phase]);
      // long response stall with the sender still pushing: input must back up
      if (phase == 8) hold_req = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        mode = $urandom_range(0, 1) ? ModePut : ModeGet;
        if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, capacity_limit() + 4)];
        else key = $urandom;
        pick = $urandom_range(0, 9);
        case (pick)
          0: val = 32'h8000_0000;
          1: val = 32'h7fff_ffff;
          2: val = 32'hffff_ffff;
          3: val = 32'h0000_0000;
          default: val = $urandom;
        endcase
        send_lookup(mode, key, val, 1'b0, 1'b0, '0);
      end
    end

    req_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_req_if.sv
hw/rtl/lkvc_rsp_if.sv
hw/rtl/lkvc_ctrl.sv
hw/rtl/lkvc_datapath.sv
hw/rtl/lru_key_value_cache_top.sv
test/lru_key_value_cache_top_test.sv
